[rtl/core/vnhf_pkg.sv]
package vnhf_pkg;

  // Fixed-point format of fractions, weights and lattice values (Q0.F)
  localparam int FRAC_BITS = 24;
  localparam logic [24:0] ONE = 25'd1 << FRAC_BITS;

  // fmix64 finalizer multipliers
  localparam logic [63:0] FMIX_M1 = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] FMIX_M2 = 64'hC4CEB9FE1A85EC53;

  // lattice coordinate multipliers; LATTICE_X also spreads the field salt index
  localparam logic [63:0] LATTICE_X = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] LATTICE_Z = 64'hC2B2AE3D27D4EB4F;

  // field scales in cells
  localparam int SCALE_BROAD   = 72;
  localparam int SCALE_MID     = 26;
  localparam int SCALE_SMALL   = 11;
  localparam int SCALE_PLATEAU = 90;
  localparam int SCALE_ROCK    = 15;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SEED  = 1'b0,
    REG_LIMIT = 1'b1
  } cfg_reg_t;

  localparam logic [9:0] LIMIT_RESET = 10'd120;
  localparam logic [9:0] HEIGHT_MIN  = 10'd4;

endpackage

[rtl/core/vnhf_if.sv]
interface vnhf_coord_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_z;

  modport source (output valid, output world_x, output world_z, input ready);
  modport sink (input valid, input world_x, input world_z, output ready);
endinterface

interface vnhf_height_if;
  logic       valid;
  logic       ready;
  logic [9:0] ground_height;

  modport source (output valid, output ground_height, input ready);
  modport sink (input valid, input ground_height, output ready);
endinterface

[rtl/core/vnhf_mul64lo.sv]
// Low 64 bits of a 64x64 product, two stages: 32x32 partial products, then sum.
module vnhf_mul64lo (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] p00;
  logic [31:0] p01;
  logic [31:0] p10;

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= 64'(a[31:0]) * 64'(b[31:0]);
      p01 <= a[31:0] * b[63:32];
      p10 <= a[63:32] * b[31:0];
      p   <= p00 + {p01 + p10, 32'd0};
    end
  end

endmodule

[rtl/core/vnhf_fmix.sv]
// fmix64 finalizer, registered from h to hash.
module vnhf_fmix
  import vnhf_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] h,
  output logic [63:0] hash
);

  logic [63:0] x1;
  logic [63:0] m1;
  logic [63:0] x2;
  logic [63:0] m2;

  assign x1 = h ^ (h >> 33);
  assign x2 = m1 ^ (m1 >> 33);

  vnhf_mul64lo u_mul1 (.clk(clk), .en(en), .a(x1), .b(FMIX_M1), .p(m1));
  vnhf_mul64lo u_mul2 (.clk(clk), .en(en), .a(x2), .b(FMIX_M2), .p(m2));

  always_ff @(posedge clk) begin
    if (en) begin
      hash <= m2 ^ (m2 >> 33);
    end
  end

endmodule

[rtl/core/vnhf_smooth.sv]
// Smoothstep of a Q0.F value, registers sq then prod; w is combinational off prod.
module vnhf_smooth
  import vnhf_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [24:0] u,
  output logic [24:0] w
);

  localparam logic [25:0] THREE = 26'(ONE) * 26'd3;

  logic [49:0] sq;
  logic [24:0] u_r;
  logic [50:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= 50'(u) * 50'(u);
      u_r  <= u;
      prod <= 51'(sq[48:24]) * 51'(THREE - {u_r, 1'b0});
    end
  end

  assign w = prod[48:24];

endmodule

[rtl/core/vnhf_axis.sv]
// One coordinate of one field: floor split by SCALE, smoothstep weight,
// lattice hash terms for cell index q and q+1.
// Timing from c at stage 0: h0/h1 at stage 6, w at stage 7.
module vnhf_axis
  import vnhf_pkg::*;
#(
  parameter int          SCALE = 72,
  parameter logic [63:0] HMUL  = 64'h9E3779B97F4A7C15
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] c,
  output logic [63:0]        h0,
  output logic [63:0]        h1,
  output logic [24:0]        w
);

  localparam int L  = $clog2(SCALE);
  localparam int QW = 33 - L;
  localparam int RW = L;
  // reciprocal, exact for 32-bit dividends
  localparam logic [32:0] M = 33'(((64'd1 << (32 + L)) + 64'(SCALE) - 64'd1) / 64'(SCALE));
  // 2^31 = A * SCALE + B, the bias that makes the dividend unsigned
  localparam logic [31:0] A = 32'((64'd1 << 31) / 64'(SCALE));
  localparam logic [31:0] B = 32'((64'd1 << 31) % 64'(SCALE));

  logic [31:0]        cu1;
  logic [64:0]        p1;
  logic [QW-1:0]      qp2;
  logic [RW-1:0]      rp2;
  logic signed [31:0] q3;
  logic [RW-1:0]      r3;
  logic [64:0]        fp4;
  logic [63:0]        hm;
  logic [24:0]        ws;

  logic [31:0]        cu;
  logic [QW-1:0]      qp;
  logic [31:0]        rfull;
  logic               lt;
  logic [RW:0]        rfix;

  assign cu    = {~c[31], c[30:0]};
  assign qp    = p1[32+L +: QW];
  assign rfull = cu1 - 32'(qp) * 32'(SCALE);
  assign lt    = 32'(rp2) < B;
  assign rfix  = lt ? ({1'b0, rp2} + (RW+1)'(32'(SCALE) - B))
                    : ({1'b0, rp2} - (RW+1)'(B));

  always_ff @(posedge clk) begin
    if (en) begin
      cu1 <= cu;
      p1  <= 65'(cu) * 65'(M);
      qp2 <= qp;
      rp2 <= rfull[RW-1:0];
      q3  <= 32'(qp2) - A - {31'd0, lt};
      r3  <= rfix[RW-1:0];
      fp4 <= 65'({r3, {FRAC_BITS{1'b0}}}) * 65'(M);
      h0  <= hm;
      h1  <= hm + HMUL;
      w   <= ws;
    end
  end

  vnhf_mul64lo u_hmul (
    .clk(clk), .en(en), .a({{32{q3[31]}}, q3}), .b(HMUL), .p(hm)
  );

  vnhf_smooth u_smooth (
    .clk(clk), .en(en), .u(fp4[32+L +: 25]), .w(ws)
  );

endmodule

[rtl/core/vnhf_lane.sv]
// One value-noise field. x/z at stage 0, n registered at stage 15.
module vnhf_lane
  import vnhf_pkg::*;
#(
  parameter int SCALE  = 72,
  parameter int SALT_K = 1
) (
  input  logic               clk,
  input  logic               en,
  input  logic [63:0]        seed,
  input  logic signed [31:0] x,
  input  logic signed [31:0] z,
  output logic [23:0]        n
);

  localparam logic [63:0] SALT_XOR = LATTICE_X * 64'(SALT_K);

  logic [63:0] hx0, hx1, hz0, hz1;
  logic [24:0] wu7, wv7;
  logic [63:0] salt;
  logic [63:0] ha, hb, hc, hd;
  logic [24:0] wu_d [0:3];
  logic [24:0] wv_d [0:5];

  logic [23:0] la, lb, lc, ld;
  logic [23:0] d_ab, d_cd, d_v;

  logic        ge_ab12, ge_cd12, ge_v14;
  logic [23:0] a12, c12, t14;
  logic [48:0] pr_ab12, pr_cd12, pr_v14;
  logic [23:0] top13, bot13;

  vnhf_axis #(.SCALE(SCALE), .HMUL(LATTICE_X)) u_ax (
    .clk(clk), .en(en), .c(x), .h0(hx0), .h1(hx1), .w(wu7)
  );
  vnhf_axis #(.SCALE(SCALE), .HMUL(LATTICE_Z)) u_az (
    .clk(clk), .en(en), .c(z), .h0(hz0), .h1(hz1), .w(wv7)
  );

  // seed must change only while the pipe is empty (unchecked), so salt settles
  vnhf_fmix u_salt (.clk(clk), .en(en), .h(seed ^ SALT_XOR), .hash(salt));

  vnhf_fmix u_ha (.clk(clk), .en(en), .h(salt ^ hx0 ^ hz0), .hash(ha));
  vnhf_fmix u_hb (.clk(clk), .en(en), .h(salt ^ hx1 ^ hz0), .hash(hb));
  vnhf_fmix u_hc (.clk(clk), .en(en), .h(salt ^ hx0 ^ hz1), .hash(hc));
  vnhf_fmix u_hd (.clk(clk), .en(en), .h(salt ^ hx1 ^ hz1), .hash(hd));

  assign la = ha[63 -: FRAC_BITS];
  assign lb = hb[63 -: FRAC_BITS];
  assign lc = hc[63 -: FRAC_BITS];
  assign ld = hd[63 -: FRAC_BITS];

  assign d_ab = (lb >= la) ? lb - la : la - lb;
  assign d_cd = (ld >= lc) ? ld - lc : lc - ld;
  assign d_v  = (bot13 >= top13) ? bot13 - top13 : top13 - bot13;

  always_ff @(posedge clk) begin
    if (en) begin
      wu_d[0] <= wu7;
      wv_d[0] <= wv7;
      for (int i = 1; i < 4; i++) wu_d[i] <= wu_d[i-1];
      for (int i = 1; i < 6; i++) wv_d[i] <= wv_d[i-1];

      // lerp along x, both rows
      ge_ab12 <= lb >= la;
      ge_cd12 <= ld >= lc;
      a12     <= la;
      c12     <= lc;
      pr_ab12 <= 49'(d_ab) * 49'(wu_d[3]);
      pr_cd12 <= 49'(d_cd) * 49'(wu_d[3]);
      top13   <= ge_ab12 ? a12 + pr_ab12[47:24] : a12 - pr_ab12[47:24];
      bot13   <= ge_cd12 ? c12 + pr_cd12[47:24] : c12 - pr_cd12[47:24];

      // lerp along z
      ge_v14 <= bot13 >= top13;
      t14    <= top13;
      pr_v14 <= 49'(d_v) * 49'(wv_d[5]);
      n      <= ge_v14 ? t14 + pr_v14[47:24] : t14 - pr_v14[47:24];
    end
  end

endmodule

[rtl/core/value_noise_height_field.sv]
// Accepted items enter x0/z0 and leave from the output register ground_reg.
// Throughput: one item per cycle; the whole pipe advances unless the output
// register holds an item that is not being taken.
// Reset (rst, synchronous, active high): clears all valid bits, seed to 0,
// height_limit to 120. No clearing pass.
module value_noise_height_field
  import vnhf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  vnhf_coord_if.sink    coord,
  vnhf_height_if.source height,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  localparam int LAST = 24;

  // plateau step edges: t = (1000 n - 600 ONE) / 35, clamped to [0, ONE]
  localparam logic [33:0] PL_LO   = 34'(ONE) * 34'd600;
  localparam logic [33:0] PL_SPAN = 34'(ONE) * 34'd35;
  localparam logic [30:0] M35     = 31'(((64'd1 << 36) + 64'd34) / 64'd35);
  // rock threshold 0.74 as 100 rock > 74 ONE
  localparam logic [30:0] ROCK_TH = 31'(ONE) * 31'd74;
  localparam logic [37:0] BASE    = 38'(ONE) * 38'd1390;
  localparam logic [37:0] ROCK_OF = 38'(ONE) * 38'd1628;
  // reciprocal for /100 of a 13-bit value
  localparam logic [13:0] M100    = 14'(((64'd1 << 20) + 64'd99) / 64'd100);

  logic [63:0] seed;
  logic [9:0]  height_limit;

  logic [LAST:0] valid_pipe;
  logic          en;

  logic signed [31:0] x0, z0;
  logic [23:0] n1, n2, n3, np, rock;

  // plateau path
  logic [33:0] scaled;
  logic [33:0] pdiff;
  logic        zero16, sat16, zero17, sat17;
  logic [29:0] diff16;
  logic [60:0] prod17;
  logic [24:0] t;
  logic [24:0] p_s;
  logic [24:0] p20;

  // field values delayed to meet the plateau value; index 0 is stage 16
  logic [23:0] n1_d [0:4];
  logic [23:0] n2_d [0:4];
  logic [23:0] n3_d [0:4];
  logic [23:0] rk_d [0:4];

  // sum and height
  logic        rock_on;
  logic [37:0] a21, b21, s22;
  logic [26:0] hp23;
  logic [9:0]  h_raw, h_cap;
  logic [9:0]  ground_reg;

  // the output register is the last stage; everything moves when it can drain
  assign en           = !valid_pipe[LAST] || height.ready;
  assign coord.ready  = en;
  assign height.valid = valid_pipe[LAST];
  assign height.ground_height = ground_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= '0;
      height_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED:  seed         <= cfg_data;
        REG_LIMIT: height_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[LAST-1:0], coord.valid};
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= coord.world_x;
      z0 <= coord.world_z;
    end
  end

  // stages 1..15: the five fields, each salted by its own index
  vnhf_lane #(.SCALE(SCALE_BROAD), .SALT_K(1)) u_broad (
    .clk(clk), .en(en), .seed(seed), .x(x0), .z(z0), .n(n1)
  );
  vnhf_lane #(.SCALE(SCALE_MID), .SALT_K(2)) u_mid (
    .clk(clk), .en(en), .seed(seed), .x(x0), .z(z0), .n(n2)
  );
  vnhf_lane #(.SCALE(SCALE_SMALL), .SALT_K(3)) u_small (
    .clk(clk), .en(en), .seed(seed), .x(x0), .z(z0), .n(n3)
  );
  vnhf_lane #(.SCALE(SCALE_PLATEAU), .SALT_K(4)) u_plateau (
    .clk(clk), .en(en), .seed(seed), .x(x0), .z(z0), .n(np)
  );
  vnhf_lane #(.SCALE(SCALE_ROCK), .SALT_K(5)) u_rock (
    .clk(clk), .en(en), .seed(seed), .x(x0), .z(z0), .n(rock)
  );

  // stage 16: plateau edge tests; stage 17: divide by 35 via reciprocal
  assign scaled = 34'(np) * 34'd1000;
  assign pdiff  = scaled - PL_LO;

  // saturated ends bypass the division
  assign t = zero17 ? 25'd0 : (sat17 ? ONE : prod17[36 +: 25]);

  // stages 18..19: narrow smoothstep of the plateau
  vnhf_smooth u_pl_smooth (.clk(clk), .en(en), .u(t), .w(p_s));

  // rock only where the plateau is below one half
  assign rock_on = (31'(rk_d[4]) * 31'd100 > ROCK_TH) && (p20 < (ONE >> 1));

  assign h_raw = {3'd0, hp23[26:20]};
  assign h_cap = (h_raw > height_limit) ? height_limit : h_raw;

  always_ff @(posedge clk) begin
    if (en) begin
      zero16 <= scaled <= PL_LO;
      sat16  <= (scaled > PL_LO) && (pdiff >= PL_SPAN);
      diff16 <= pdiff[29:0];
      zero17 <= zero16;
      sat17  <= sat16;
      prod17 <= 61'(diff16) * 61'(M35);
      p20    <= p_s;

      n1_d[0] <= n1;
      n2_d[0] <= n2;
      n3_d[0] <= n3;
      rk_d[0] <= rock;
      for (int i = 1; i < 5; i++) begin
        n1_d[i] <= n1_d[i-1];
        n2_d[i] <= n2_d[i-1];
        n3_d[i] <= n3_d[i-1];
        rk_d[i] <= rk_d[i-1];
      end

      // stage 21: exact sum S in Q.F, split in two halves
      a21 <= 38'(n1_d[4]) * 38'd1800 + 38'(n2_d[4]) * 38'd600 + 38'(n3_d[4]) * 38'd220;
      b21 <= BASE + 38'(p20) * 38'd900
           + (rock_on ? 38'(rk_d[4]) * 38'd2200 - ROCK_OF : 38'd0);
      // stage 22
      s22 <= a21 + b21;
      // stage 23: floor(S / 2^F) / 100
      hp23 <= 27'(s22[36:24]) * 27'(M100);
      // stage 24: clamp; lower bound last so a tiny limit still gives four
      ground_reg <= (h_cap < HEIGHT_MIN) ? HEIGHT_MIN : h_cap;
    end
  end

endmodule

[rtl/core/vnhf_checker.sv]
module vnhf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] ground_height
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ground_height))
    else $error("result changed under stall");

  // input side stalls exactly when the output register is full and blocked
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output drain");

  // heights stay within the floor and a bound above the fields' largest sum
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ground_height >= 10'd4 && ground_height <= 10'd54)
    else $error("height out of range");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind value_noise_height_field vnhf_checker u_vnhf_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(coord.valid),
  .in_ready(coord.ready),
  .out_valid(height.valid),
  .out_ready(height.ready),
  .ground_height(height.ground_height)
);
